// ===== hw/rtl/mdf_pkg.sv =====
// ----------------------------------------------------------------------------
// mdf_pkg
// Shared types, sizes and codes for the mailbox descriptor FIFO.
// ----------------------------------------------------------------------------
package mdf_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int WORD_BITS = 32;

	localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
	localparam int LEN_W   = 16;
	localparam int SLOTS_W = 5;
	localparam int CFG_W   = 16;
	localparam int REG_W   = 2;

	localparam logic [REG_W-1:0] REG_CONFIGURED = REG_W'(0);
	localparam logic [REG_W-1:0] REG_SLOTS      = REG_W'(1);
	localparam logic [REG_W-1:0] REG_ENTRY      = REG_W'(2);

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_CFG   = 3'd1;
	localparam logic [2:0] ST_TOO_LONG  = 3'd2;
	localparam logic [2:0] ST_TIMEOUT   = 3'd3;
	localparam logic [2:0] ST_MUST_WAIT = 3'd4;
	localparam logic [2:0] ST_IRQ_WAIT  = 3'd5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [31:0] message_word;
		logic [15:0] msg_length;
		logic        may_wait;
		logic        from_interrupt;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] read_word;
		logic [15:0] read_length;
		logic        box_empty;
		logic        box_full;
		logic [4:0]  used_slots;
		logic [4:0]  peak_slots;
	} rsp_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [LEN_W-1:0]     length;
	} slot_t;

	typedef struct packed {
		logic             configured;
		logic [CNT_W-1:0] depth;
		logic [LEN_W-1:0] entry_bytes;
		logic             ring_clear;
	} cfg_t;

	function automatic logic [CNT_W-1:0] depth_of(input logic [SLOTS_W-1:0] v);
		if (v == '0) return CNT_W'(1);
		if (int'(v) > MAX_SLOTS) return CNT_W'(MAX_SLOTS);
		return CNT_W'(v);
	endfunction

	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] dep);
		logic [CNT_W:0] n;
		n = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
		if (n >= {1'b0, dep}) return '0;
		return IDX_W'(n);
	endfunction

endpackage

// ===== hw/rtl/mdf_req_if.sv =====
// ----------------------------------------------------------------------------
// mdf_req_if
// Request channel: valid/ready handshake carrying one access per beat.
// ----------------------------------------------------------------------------
interface mdf_req_if;
	import mdf_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mdf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mdf_rsp_if
// Result channel: valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface mdf_rsp_if;
	import mdf_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mdf_slot_ram.sv =====
// ----------------------------------------------------------------------------
// mdf_slot_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mdf_slot_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/mdf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mdf_cfg_regs
// Configuration registers; flags a ring reset on setup writes.
// ----------------------------------------------------------------------------
module mdf_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [mdf_pkg::REG_W-1:0] wr_index,
	input  logic [mdf_pkg::CFG_W-1:0] wr_data,
	output mdf_pkg::cfg_t             cfg
);
	import mdf_pkg::*;

	logic             configured_q;
	logic [CNT_W-1:0] depth_q;
	logic [LEN_W-1:0] entry_q;
	logic             clear;

	always_comb begin
		clear = 1'b0;
		if (wr_en) begin
			case (wr_index)
				REG_CONFIGURED: clear = !configured_q && wr_data[0];
				REG_SLOTS:      clear = 1'b1;
				REG_ENTRY:      clear = 1'b1;
				default:        clear = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			configured_q <= 1'b0;
			depth_q      <= depth_of(SLOTS_W'(16));
			entry_q      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CONFIGURED: configured_q <= wr_data[0];
				REG_SLOTS:      depth_q      <= depth_of(wr_data[SLOTS_W-1:0]);
				REG_ENTRY:      entry_q      <= wr_data[LEN_W-1:0];
				default:        ;
			endcase
		end
	end

	assign cfg.configured  = configured_q;
	assign cfg.depth       = depth_q;
	assign cfg.entry_bytes = entry_q;
	assign cfg.ring_clear  = clear;
endmodule

// ===== hw/rtl/mdf_ring_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdf_ring_ctrl
// Ring pointers, flags and counters around the slot RAM; one access at a time.
// ----------------------------------------------------------------------------
module mdf_ring_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  mdf_pkg::cfg_t cfg,
	mdf_req_if.sink       req,
	output logic          res_valid,
	output mdf_pkg::rsp_t res,
	input  logic          res_ready
);
	import mdf_pkg::*;

	logic             busy_q;
	req_t             item_s1;
	logic [IDX_W-1:0] wr_idx_q, rd_idx_q;
	logic [CNT_W-1:0] held_q, peak_q;
	logic             full_q, empty_q;

	slot_t            rd_slot, wr_slot;
	logic             accept, commit;
	logic             do_wr, do_rd;
	logic [2:0]       status;
	logic [IDX_W-1:0] wr_idx_n, rd_idx_n;
	logic [CNT_W-1:0] held_n, peak_n;
	logic             full_n, empty_n;
	logic [LEN_W-1:0] rlen;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign res_valid = busy_q;
	assign commit    = busy_q && res_ready;

	assign wr_slot.word   = WORD_BITS'(item_s1.message_word);
	assign wr_slot.length = item_s1.msg_length;

	mdf_slot_ram #(
		.DEPTH (MAX_SLOTS),
		.WIDTH ($bits(slot_t)),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (commit && do_wr),
		.waddr (wr_idx_q),
		.wdata (wr_slot),
		.re    (accept),
		.raddr (rd_idx_q),
		.rdata (rd_slot)
	);

	always_comb begin
		do_wr  = 1'b0;
		do_rd  = 1'b0;
		status = ST_OK;
		if (item_s1.from_interrupt && item_s1.may_wait) begin
			status = ST_IRQ_WAIT;
		end else if (!cfg.configured) begin
			status = ST_NOT_CFG;
		end else if (item_s1.cmd == CMD_WRITE) begin
			if (cfg.entry_bytes != '0 && item_s1.msg_length > cfg.entry_bytes) begin
				status = ST_TOO_LONG;
			end else if (full_q) begin
				status = item_s1.may_wait ? ST_MUST_WAIT : ST_TIMEOUT;
			end else begin
				do_wr = 1'b1;
			end
		end else begin
			if (empty_q) begin
				status = item_s1.may_wait ? ST_MUST_WAIT : ST_TIMEOUT;
			end else begin
				do_rd = 1'b1;
			end
		end

		wr_idx_n = wr_idx_q;
		rd_idx_n = rd_idx_q;
		held_n   = held_q;
		peak_n   = peak_q;
		full_n   = full_q;
		empty_n  = empty_q;
		if (do_wr) begin
			wr_idx_n = advance(wr_idx_q, cfg.depth);
			if (held_q < CNT_W'(MAX_SLOTS)) begin
				held_n = held_q + CNT_W'(1);
			end
			if (held_n > peak_q) begin
				peak_n = held_n;
			end
			empty_n = 1'b0;
			if (wr_idx_n == rd_idx_q) begin
				full_n = 1'b1;
			end
		end
		if (do_rd) begin
			rd_idx_n = advance(rd_idx_q, cfg.depth);
			if (held_q != '0) begin
				held_n = held_q - CNT_W'(1);
			end
			full_n = 1'b0;
			if (rd_idx_n == wr_idx_q) begin
				empty_n = 1'b1;
			end
		end

		if (cfg.entry_bytes != '0 && item_s1.msg_length != '0
			&& item_s1.msg_length <= rd_slot.length) begin
			rlen = item_s1.msg_length;
		end else begin
			rlen = rd_slot.length;
		end

		res.status      = status;
		res.read_word   = do_rd ? 32'(rd_slot.word) : '0;
		res.read_length = do_rd ? rlen : '0;
		res.box_empty   = empty_n;
		res.box_full    = full_n;
		res.used_slots  = 5'(held_n);
		res.peak_slots  = 5'(peak_n);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			held_q   <= '0;
			peak_q   <= '0;
			full_q   <= 1'b0;
			empty_q  <= 1'b1;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (cfg.ring_clear) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
				held_q   <= '0;
				full_q   <= 1'b0;
				empty_q  <= 1'b1;
			end else if (commit) begin
				wr_idx_q <= wr_idx_n;
				rd_idx_q <= rd_idx_n;
				held_q   <= held_n;
				peak_q   <= peak_n;
				full_q   <= full_n;
				empty_q  <= empty_n;
			end
		end
	end

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full_q && empty_q))
		else $error("ring both full and empty");

	a_empty_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q == (held_q == '0))
		else $error("empty flag disagrees with held count");

	a_peak_covers_held: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= peak_q)
		else $error("peak below held count");

	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> !busy_q)
		else $error("still busy after result taken");
endmodule

// ===== hw/rtl/mailbox_descriptor_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// mailbox_descriptor_fifo_unit
// Ring mailbox of message slots with full/empty flags and peak watermark.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one access per beat (cmd, message_word, msg_length, may_wait,
//          from_interrupt). A write stores a slot, a read drains one.
//   rsp  : one result beat per access: status, read word and length,
//          flags, used and peak slot counts after the access.
//   wr_en/wr_index/wr_data : register writes, only while the block is idle.
//          Index 0 box_configured, 1 slots_in_use, 2 entry_bytes.
// Timing: the slot RAM is read at the edge that accepts a beat; the result
//   is formed in the next cycle and lands in the output register once that
//   register can take it. A new access is accepted only after the last result
//   has left, set by the read-then-update turn around the registered slot RAM.
// Reset: ring empty, pointers and counts zero, box not configured, depth 16,
//   by-reference mode. Slot contents are not cleared and need no sweep.
// Stall: a result held in the output register does not block the next
//   access, which is computed and then waits until the register frees.
// ----------------------------------------------------------------------------
module mailbox_descriptor_fifo_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	mdf_req_if.sink                   req,
	mdf_rsp_if.source                 rsp,
	input  logic                      wr_en,
	input  logic [mdf_pkg::REG_W-1:0] wr_index,
	input  logic [mdf_pkg::CFG_W-1:0] wr_data
);
	import mdf_pkg::*;

	cfg_t cfg;
	rsp_t res;
	logic res_valid, res_ready;
	rsp_t out_q;
	logic out_valid_q;

	mdf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	mdf_ring_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
endmodule
